// File: design/rvc_pkg.sv
package rvc_pkg;

	// Fixed field widths
	localparam int DIM_W  = 13;
	localparam int CRD_W  = 12;
	localparam int PIX_W  = 8;
	localparam int COEF_W = 16;
	localparam int NCH    = 3;
	localparam int CFG_W  = 16;

	// Largest frame dimension honored; larger settings are clamped
	localparam int MAX_DIM = 4096;

	// Fixed-point formats: r2 in Q1.16, coefficients in Q3.12
	localparam int COEF_FRAC_BITS = 12;
	localparam int R2_FRAC        = 16;
	localparam int R_W            = R2_FRAC + 1;
	localparam int MASK_SHIFT     = COEF_FRAC_BITS + R2_FRAC;

	// Register reset values
	localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

	typedef enum logic [2:0] {
		CFG_WIDTH  = 3'd0,
		CFG_HEIGHT = 3'd1,
		CFG_COEF_A = 3'd2,
		CFG_COEF_B = 3'd3,
		CFG_COEF_C = 3'd4,
		CFG_ENABLE = 3'd5
	} cfg_idx_t;

	typedef logic [NCH-1:0][PIX_W-1:0] pix_t;

endpackage

// File: design/rvc_div.sv
module rvc_div #(
	parameter int NUM_W  = 37,
	parameter int DEN_W  = 35,
	parameter int Q_W    = 8,
	parameter int LANES  = 1,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              en,
	input  logic [NUM_W-1:0]  num [LANES],
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side,
	output logic [Q_W-1:0]    quo [LANES],
	output logic              ovf [LANES],
	output logic [SIDE_W-1:0] side_out
);

	// Working width holds the numerator and the divisor at its largest shift
	localparam int W = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

	logic [W-1:0]      rem_s  [Q_W+1][LANES];
	logic [Q_W-1:0]    quo_s  [Q_W+1][LANES];
	logic              ovf_s  [Q_W+1][LANES];
	logic [DEN_W-1:0]  den_s  [Q_W+1];
	logic [SIDE_W-1:0] side_s [Q_W+1];

	// Entry stage: load dividend, flag quotients that do not fit in Q_W bits
	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0]  <= den;
			side_s[0] <= side;
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_entry
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[0][l] <= W'(num[l]);
				quo_s[0][l] <= '0;
				ovf_s[0][l] <= W'(num[l]) >= (W'(den) << Q_W);
			end
		end
	end

	// One restoring step per stage, most significant quotient bit first
	for (genvar k = 1; k <= Q_W; k++) begin : g_step
		localparam int B = Q_W - k;

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [W-1:0] sub;
			logic         ge;

			assign sub = W'(den_s[k-1]) << B;
			assign ge  = rem_s[k-1][l] >= sub;

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k][l] <= ge ? rem_s[k-1][l] - sub : rem_s[k-1][l];
					quo_s[k][l] <= quo_s[k-1][l] | (Q_W'(ge) << B);
					ovf_s[k][l] <= ovf_s[k-1][l];
				end
			end
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_out
		assign quo[l] = quo_s[Q_W][l];
		assign ovf[l] = ovf_s[Q_W][l];
	end
	assign side_out = side_s[Q_W];

endmodule

// File: design/radial_vignetting_correction.sv
// Radial lens shading correction.
// Pixel channel: col, row and three 8-bit channels, with pixel_valid and
// pixel_stall. Result channel: out_c0..out_c2 with result_valid and
// result_stall. A transfer happens on a clock edge where valid is high and
// stall is low.
// Configuration channel: cfg_index selects width, height, coef_a, coef_b,
// coef_c or enable; cfg_data is written when cfg_valid and cfg_ready are
// high. cfg_ready is always high. Write only while no pixel is in flight.
// One pixel enters every cycle unless the pipeline holds. The pipeline
// includes the 18-stage radius divider and the 9-stage channel divider,
// each an entry stage plus one quotient bit per stage.
// Reset clears the pipeline valid bits and loads 640x480, zero coefficients
// and correction disabled, so pixels pass through unchanged.
// When the receiver stalls a waiting result, the whole pipeline holds and
// pixel_stall rises in the same cycle; nothing is dropped or repeated.
module radial_vignetting_correction (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      pixel_valid,
	output logic                      pixel_stall,
	input  logic [rvc_pkg::CRD_W-1:0] col,
	input  logic [rvc_pkg::CRD_W-1:0] row,
	input  logic [rvc_pkg::PIX_W-1:0] pix_c0,
	input  logic [rvc_pkg::PIX_W-1:0] pix_c1,
	input  logic [rvc_pkg::PIX_W-1:0] pix_c2,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic [rvc_pkg::PIX_W-1:0] out_c0,
	output logic [rvc_pkg::PIX_W-1:0] out_c1,
	output logic [rvc_pkg::PIX_W-1:0] out_c2,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [2:0]                cfg_index,
	input  logic [rvc_pkg::CFG_W-1:0] cfg_data
);
	import rvc_pkg::*;

	localparam int DX_W  = CRD_W + 3;
	localparam int SQ_W  = 2 * DX_W;
	localparam int N_W   = 2 * CRD_W + 3;
	localparam int D_W   = 2 * DIM_W;
	localparam int X_W   = N_W + R2_FRAC;
	localparam int RP_W  = 2 * R_W;
	localparam int P_W   = COEF_W + R_W + 1;
	localparam int M_W   = P_W + 2;
	localparam int DM_W  = M_W - 1;
	localparam int CN_W  = PIX_W + MASK_SHIFT + 1;
	localparam int LAT   = 4 + (R_W + 1) + 6 + (PIX_W + 1) + 1;
	localparam int R_STG = 4 + R_W + 1;
	localparam int RS_W  = $bits(pix_t) + 1;
	localparam int CS_W  = $bits(pix_t) + 2;

	localparam logic [R_W-1:0]  R_ONE  = R_W'(1) << R2_FRAC;
	localparam logic [RP_W-1:0] R_HALF = RP_W'(1) << (R2_FRAC - 1);
	localparam logic [PIX_W-1:0] PIX_MAX = '1;

	// Configuration registers
	logic [DIM_W-1:0]         frame_width_q, frame_height_q;
	logic signed [COEF_W-1:0] coef_a_q, coef_b_q, coef_c_q;
	logic                     enable_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RST;
			frame_height_q <= HEIGHT_RST;
			coef_a_q       <= '0;
			coef_b_q       <= '0;
			coef_c_q       <= '0;
			enable_q       <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WIDTH:  frame_width_q  <= cfg_data[DIM_W-1:0];
				CFG_HEIGHT: frame_height_q <= cfg_data[DIM_W-1:0];
				CFG_COEF_A: coef_a_q       <= cfg_data;
				CFG_COEF_B: coef_b_q       <= cfg_data;
				CFG_COEF_C: coef_c_q       <= cfg_data;
				CFG_ENABLE: enable_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamped dimensions and bypass condition
	logic [DIM_W-1:0] w_c, h_c;
	logic             bypass;

	assign w_c = (frame_width_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : frame_width_q;
	assign h_c = (frame_height_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : frame_height_q;
	assign bypass = !enable_q || (coef_a_q == '0 && coef_b_q == '0 && coef_c_q == '0);

	// Global advance: the pipeline holds while a result waits
	logic [LAT-1:0] vld_q;
	logic           adv;

	assign adv          = !(vld_q[LAT-1] && result_stall);
	assign pixel_stall  = !adv;
	assign result_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], pixel_valid};
		end
	end

	// s1: input register
	logic [CRD_W-1:0] col_s1, row_s1;
	pix_t             pix_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1 <= col;
			row_s1 <= row;
			pix_s1 <= {pix_c2, pix_c1, pix_c0};
		end
	end

	// s2: offsets from the frame center, doubled
	logic signed [DX_W-1:0] dx_s2, dy_s2;
	pix_t                   pix_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s2  <= signed'({2'b0, col_s1, 1'b0}) - signed'({2'b0, w_c});
			dy_s2  <= signed'({2'b0, row_s1, 1'b0}) - signed'({2'b0, h_c});
			pix_s2 <= pix_s1;
		end
	end

	// s3: squared distance and normalization denominator
	logic signed [SQ_W-1:0] sqx, sqy;
	logic [N_W-1:0]         n_s3;
	logic [D_W-1:0]         d_s3;
	pix_t                   pix_s3;

	assign sqx = dx_s2 * dx_s2;
	assign sqy = dy_s2 * dy_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s3   <= N_W'(unsigned'(sqx)) + N_W'(unsigned'(sqy));
			d_s3   <= D_W'(w_c) * D_W'(w_c) + D_W'(h_c) * D_W'(h_c);
			pix_s3 <= pix_s2;
		end
	end

	// s4: rounded dividend for r2
	logic [X_W-1:0] x_s4;
	logic [D_W-1:0] d_s4;
	logic           dz_s4;
	pix_t           pix_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s4   <= (X_W'(n_s3) << R2_FRAC) + X_W'(d_s3 >> 1);
			d_s4   <= d_s3;
			dz_s4  <= d_s3 == '0;
			pix_s4 <= pix_s3;
		end
	end

	// Radius divider
	logic [X_W-1:0]  rdiv_num [1];
	logic [R_W-1:0]  rdiv_quo [1];
	logic            rdiv_ovf [1];
	logic [RS_W-1:0] rdiv_side;

	assign rdiv_num[0] = x_s4;

	rvc_div #(
		.NUM_W (X_W),
		.DEN_W (D_W),
		.Q_W   (R_W),
		.LANES (1),
		.SIDE_W(RS_W)
	) u_rdiv (
		.clk     (clk),
		.en      (adv),
		.num     (rdiv_num),
		.den     (d_s4),
		.side    ({dz_s4, pix_s4}),
		.quo     (rdiv_quo),
		.ovf     (rdiv_ovf),
		.side_out(rdiv_side)
	);

	// s5: r2 saturated to 1.0
	logic [R_W-1:0] r_s5;
	pix_t           pix_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (rdiv_side[RS_W-1])
				r_s5 <= '0;
			else if (rdiv_ovf[0] || rdiv_quo[0] > R_ONE)
				r_s5 <= R_ONE;
			else
				r_s5 <= rdiv_quo[0];
			pix_s5 <= rdiv_side[RS_W-2:0];
		end
	end

	// s6: r2 squared
	logic [RP_W-1:0] rr_prod;
	logic [R_W-1:0]  r1_s6, r2_s6;
	pix_t            pix_s6;

	assign rr_prod = RP_W'(r_s5) * RP_W'(r_s5);

	always_ff @(posedge clk) begin
		if (adv) begin
			r1_s6  <= r_s5;
			r2_s6  <= R_W'((rr_prod + R_HALF) >> R2_FRAC);
			pix_s6 <= pix_s5;
		end
	end

	// s7: r2 cubed
	logic [RP_W-1:0] rrr_prod;
	logic [R_W-1:0]  r1_s7, r2_s7, r3_s7;
	pix_t            pix_s7;

	assign rrr_prod = RP_W'(r2_s6) * RP_W'(r1_s6);

	always_ff @(posedge clk) begin
		if (adv) begin
			r1_s7  <= r1_s6;
			r2_s7  <= r2_s6;
			r3_s7  <= R_W'((rrr_prod + R_HALF) >> R2_FRAC);
			pix_s7 <= pix_s6;
		end
	end

	// s8: coefficient products
	logic signed [P_W-1:0] pa_s8, pb_s8, pc_s8;
	pix_t                  pix_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s8  <= coef_a_q * signed'({1'b0, r1_s7});
			pb_s8  <= coef_b_q * signed'({1'b0, r2_s7});
			pc_s8  <= coef_c_q * signed'({1'b0, r3_s7});
			pix_s8 <= pix_s7;
		end
	end

	// s9: mask
	logic signed [M_W-1:0] m_s9;
	pix_t                  pix_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s9   <= (M_W'(1) <<< MASK_SHIFT) + M_W'(pa_s8) + M_W'(pb_s8) + M_W'(pc_s8);
			pix_s9 <= pix_s8;
		end
	end

	// s10: rounded channel dividends and mask sign flags
	logic [CN_W-1:0] num_s10 [NCH];
	logic [DM_W-1:0] den_s10;
	logic            mneg_s10, mzero_s10;
	pix_t            pix_s10;

	for (genvar c = 0; c < NCH; c++) begin : g_cnum
		always_ff @(posedge clk) begin
			if (adv)
				num_s10[c] <= (CN_W'(pix_s9[c]) << MASK_SHIFT) + CN_W'(m_s9[DM_W-1:1]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s10   <= m_s9[DM_W-1:0];
			mneg_s10  <= m_s9 < 0;
			mzero_s10 <= m_s9 == '0;
			pix_s10   <= pix_s9;
		end
	end

	// Channel divider, one lane per channel, shared mask
	logic [PIX_W-1:0] cdiv_quo [NCH];
	logic             cdiv_ovf [NCH];
	logic [CS_W-1:0]  cdiv_side;
	pix_t             pix_d;
	logic             mneg_d, mzero_d;

	rvc_div #(
		.NUM_W (CN_W),
		.DEN_W (DM_W),
		.Q_W   (PIX_W),
		.LANES (NCH),
		.SIDE_W(CS_W)
	) u_cdiv (
		.clk     (clk),
		.en      (adv),
		.num     (num_s10),
		.den     (den_s10),
		.side    ({mneg_s10, mzero_s10, pix_s10}),
		.quo     (cdiv_quo),
		.ovf     (cdiv_ovf),
		.side_out(cdiv_side)
	);

	assign mneg_d  = cdiv_side[CS_W-1];
	assign mzero_d = cdiv_side[CS_W-2];
	assign pix_d   = cdiv_side[CS_W-3:0];

	// s11: output register with special cases and bypass
	pix_t out_s11;

	for (genvar c = 0; c < NCH; c++) begin : g_res
		always_ff @(posedge clk) begin
			if (adv) begin
				if (bypass)
					out_s11[c] <= pix_d[c];
				else if (mneg_d)
					out_s11[c] <= '0;
				else if (mzero_d)
					out_s11[c] <= (pix_d[c] != '0) ? PIX_MAX : '0;
				else if (cdiv_ovf[c])
					out_s11[c] <= PIX_MAX;
				else
					out_s11[c] <= cdiv_quo[c];
			end
		end
	end

	assign out_c0 = out_s11[0];
	assign out_c1 = out_s11[1];
	assign out_c2 = out_s11[2];

	// A waiting result holds the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |-> pixel_stall)
		else $error("input accepted while result is stalled");

	// Valid bits freeze while the pipeline holds
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("valid bits moved during a hold");

	// Normalized radius never exceeds 1.0
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[R_STG] |-> r_s5 <= R_ONE)
		else $error("r2 above 1.0");

endmodule

// File: sim/tb_radial_vignetting_correction.sv
module tb_radial_vignetting_correction;
	import rvc_pkg::*;

	// Indexes the block has no register for; writes there must be ignored
	localparam logic [2:0] UNMAPPED_IDX_LO = 3'd6;
	localparam logic [2:0] UNMAPPED_IDX_HI = 3'd7;
	localparam int PIPE_DRAIN = 45;

	// Expected corrected pixels and the shading math that produces them
	class shading_scoreboard;
		pix_t     corrected_q[$];
		int       errors;
		longint   width, height, ca, cb, cc;
		bit       enable;

		function new();
			width  = WIDTH_RST;
			height = HEIGHT_RST;
			ca = 0; cb = 0; cc = 0;
			enable = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				CFG_WIDTH:  width  = data[DIM_W-1:0];
				CFG_HEIGHT: height = data[DIM_W-1:0];
				CFG_COEF_A: ca = $signed(data);
				CFG_COEF_B: cb = $signed(data);
				CFG_COEF_C: cc = $signed(data);
				CFG_ENABLE: enable = data[0];
				default: ;
			endcase
		endfunction

		// Normalized squared radius in Q1.16, saturated at 1.0
		function longint radius_sq(longint x, longint y);
			longint wc, hc, dx, dy, n, d, r;
			wc = (width > MAX_DIM) ? MAX_DIM : width;
			hc = (height > MAX_DIM) ? MAX_DIM : height;
			dx = 2 * x - wc;
			dy = 2 * y - hc;
			n = dx * dx + dy * dy;
			d = wc * wc + hc * hc;
			if (d == 0)
				return 0;
			r = (n * (64'sd1 <<< R2_FRAC) + d / 2) / d;
			return (r > (64'sd1 <<< R2_FRAC)) ? (64'sd1 <<< R2_FRAC) : r;
		endfunction

		function logic [PIX_W-1:0] divide_channel(longint p, longint mask);
			longint q;
			if (mask < 0)
				return 8'd0;
			if (mask == 0)
				return (p != 0) ? 8'd255 : 8'd0;
			q = ((p <<< MASK_SHIFT) + mask / 2) / mask;
			return (q > 255) ? 8'd255 : q[PIX_W-1:0];
		endfunction

		function void note_pixel(logic [CRD_W-1:0] x, logic [CRD_W-1:0] y, pix_t p);
			pix_t   res;
			longint r1, r2, r3, mask;
			if (!enable || (ca == 0 && cb == 0 && cc == 0)) begin
				res = p;
			end else begin
				r1 = radius_sq(x, y);
				r2 = (r1 * r1 + (64'sd1 <<< (R2_FRAC - 1))) >>> R2_FRAC;
				r3 = (r2 * r1 + (64'sd1 <<< (R2_FRAC - 1))) >>> R2_FRAC;
				mask = (64'sd1 <<< MASK_SHIFT) + ca * r1 + cb * r2 + cc * r3;
				for (int i = 0; i < NCH; i++)
					res[i] = divide_channel(p[i], mask);
			end
			corrected_q.push_back(res);
		endfunction

		function void check_result(pix_t got);
			pix_t want;
			if (corrected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result transfer: %h %h %h", got[0], got[1], got[2]);
				return;
			end
			want = corrected_q.pop_front();
			for (int i = 0; i < NCH; i++) begin
				if (got[i] !== want[i]) begin
					errors++;
					if (errors <= 10)
						$display("channel %0d: expected %0d, got %0d", i, want[i], got[i]);
				end
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                pixel_valid;
	logic                pixel_stall;
	logic [CRD_W-1:0]    col, row;
	logic [PIX_W-1:0]    pix_c0, pix_c1, pix_c2;
	logic                result_valid;
	logic                result_stall;
	logic [PIX_W-1:0]    out_c0, out_c1, out_c2;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [2:0]          cfg_index;
	logic [CFG_W-1:0]    cfg_data;

	shading_scoreboard sb;
	bit tx_idle_on;
	bit rx_idle_on;
	bit rx_hold_req;

	radial_vignetting_correction DUT (.*);

	always #5 clk = ~clk;

	// Pixel transfer; valid stays high across back-to-back items
	task automatic send_pixel(logic [CRD_W-1:0] x, logic [CRD_W-1:0] y,
			logic [PIX_W-1:0] a, logic [PIX_W-1:0] b, logic [PIX_W-1:0] c);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		col <= x;
		row <= y;
		pix_c0 <= a;
		pix_c1 <= b;
		pix_c2 <= c;
		do @(negedge clk); while (pixel_stall);
		sb.note_pixel(x, y, {c, b, a});
		@(posedge clk);
	endtask

	task automatic send_random(bit anywhere);
		logic [CRD_W-1:0] x, y;
		longint wc, hc;
		wc = (sb.width > MAX_DIM) ? MAX_DIM : sb.width;
		hc = (sb.height > MAX_DIM) ? MAX_DIM : sb.height;
		x = (anywhere || wc == 0) ? CRD_W'($urandom) : CRD_W'($urandom_range(0, 32'(wc - 1)));
		y = (anywhere || hc == 0) ? CRD_W'($urandom) : CRD_W'($urandom_range(0, 32'(hc - 1)));
		send_pixel(x, y, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
	endtask

	// Register writes happen only with the pipeline empty
	task automatic drain();
		pixel_valid <= 1'b0;
		while (sb.corrected_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic configure(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic [CFG_W-1:0] a,
			logic [CFG_W-1:0] b, logic [CFG_W-1:0] c, logic [CFG_W-1:0] en);
		drain();
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		write_reg(CFG_COEF_A, a);
		write_reg(CFG_COEF_B, b);
		write_reg(CFG_COEF_C, c);
		write_reg(CFG_ENABLE, en);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Result side: random stalls, one long hold on request
	initial begin
		int w;
		bit held;
		held = 0;
		result_stall = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_req && !held) begin
				result_stall <= 1'b1;
				repeat (300) @(posedge clk);
				held = 1;
			end
			w = rx_idle_on ? $urandom_range(0, 12) : 0;
			if (w > 0) begin
				result_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(negedge clk); while (!result_valid);
			sb.check_result({out_c2, out_c1, out_c0});
			@(posedge clk);
		end
	end

	initial begin
		#5000000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		logic [CFG_W-1:0] w, h, a, b, c;
		sb = new();
		clk = 0;
		arst_n = 0;
		pixel_valid = 0;
		col = 0; row = 0;
		pix_c0 = 0; pix_c1 = 0; pix_c2 = 0;
		cfg_valid = 0;
		cfg_index = 0;
		cfg_data = 0;
		tx_idle_on = 1;
		rx_idle_on = 1;
		rx_hold_req = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings pass pixels through
		send_pixel(0, 0, 8'd0, 8'd255, 8'd0);
		send_pixel(12'hFFF, 12'hFFF, 8'd255, 8'd0, 8'd255);
		send_pixel(320, 240, 8'hAA, 8'h55, 8'h0F);

		// Enabled but all coefficients zero: still pass-through
		configure(640, 480, 0, 0, 0, 1);
		send_pixel(0, 0, 8'd17, 8'd200, 8'd255);

		// Ordinary profile that darkens toward the corners
		configure(640, 480, 16'h0800, 16'hFC00, 16'h0100, 1);
		send_pixel(320, 240, 8'd100, 8'd200, 8'd255);
		send_pixel(0, 0, 8'd100, 8'd200, 8'd255);
		send_pixel(639, 479, 8'd1, 8'd128, 8'd0);
		send_pixel(12'hFFF, 0, 8'd50, 8'd60, 8'd70);

		// Mask falls to exactly zero outside the frame
		configure(100, 100, 16'hF000, 0, 0, 1);
		send_pixel(12'hFFF, 12'hFFF, 8'd0, 8'd1, 8'd255);
		send_pixel(50, 50, 8'd0, 8'd1, 8'd255);

		// Negative mask at the corner
		configure(100, 100, 16'h8000, 16'h8000, 16'h8000, 1);
		send_pixel(0, 0, 8'd10, 8'd0, 8'd255);
		send_pixel(99, 0, 8'd255, 8'd255, 8'd255);

		// Zero-sized frame, then oversized dimensions clamped
		configure(0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1);
		send_pixel(7, 9, 8'd255, 8'd128, 8'd1);
		configure(16'h1FFF, 16'hFFFF, 16'h7FFF, 16'h0000, 16'h8000, 16'hFFFF);
		send_pixel(0, 12'hFFF, 8'd255, 8'd128, 8'd1);
		send_pixel(2048, 2048, 8'd255, 8'd128, 8'd1);

		// Writes to unmapped indexes change nothing
		drain();
		write_reg(UNMAPPED_IDX_LO, 16'hFFFF);
		write_reg(UNMAPPED_IDX_HI, 16'h0000);
		cfg_valid <= 1'b0;
		@(posedge clk);
		send_pixel(1, 1, 8'd90, 8'd91, 8'd92);

		// Random settings, mostly realistic, some at the extremes
		for (int ph = 0; ph < 12; ph++) begin
			case ($urandom_range(0, 5))
				0: begin
					w = $urandom_range(0, 1) ? CFG_W'(1) : CFG_W'(16'h1FFF);
					h = CFG_W'($urandom);
				end
				1: begin
					w = CFG_W'($urandom_range(1, 8));
					h = CFG_W'($urandom_range(1, 8));
				end
				default: begin
					w = CFG_W'($urandom_range(1, 4096));
					h = CFG_W'($urandom_range(1, 4096));
				end
			endcase
			if ($urandom_range(0, 2) == 0) begin
				a = CFG_W'($urandom); b = CFG_W'($urandom); c = CFG_W'($urandom);
			end else begin
				a = CFG_W'($urandom_range(0, 8192));
				b = 16'($signed($urandom_range(0, 4096)) - 2048);
				c = 16'($signed($urandom_range(0, 2048)) - 1024);
			end
			configure(w, h, a, b, c, (ph % 5 == 4) ? 16'd0 : 16'($urandom | 1));
			tx_idle_on = (ph % 4 != 1);
			rx_idle_on = (ph % 3 != 2);
			if (ph == 3)
				rx_hold_req = 1;
			for (int k = 0; k < 155; k++)
				send_random($urandom_range(0, 7) == 0);
		end

		drain();
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: sim.f
design/rvc_pkg.sv
design/rvc_div.sv
design/radial_vignetting_correction.sv
sim/tb_radial_vignetting_correction.sv
